// ===== hdl/cube_map_face_select_uv_unit_assert.svh =====
// Assertion macros shared by the cube map face selection modules.
// The using module must provide clk and arst_n; no other dependencies.
`ifndef CUBE_MAP_FACE_SELECT_UV_UNIT_ASSERT_SVH
`define CUBE_MAP_FACE_SELECT_UV_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CMFS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cmfs: assertion failed");

// Next-cycle implication, checked out of reset.
`define CMFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cmfs: assertion failed");

`endif

// ===== hdl/cmfs_pkg.sv =====
// Shared types and constants for the cube map face selection unit.
// No dependencies; imported by every module of the unit.
package cmfs_pkg;

	// Default number of fraction bits of the face coordinates.
	localparam int unsigned CMFS_FRAC_BITS = 16;
	// Default depth of the queue between the classifier and the divider.
	localparam int unsigned CMFS_FIFO_DEPTH = 4;
	// Width of one direction component and of its magnitude.
	localparam int unsigned CMFS_DIR_W = 16;
	localparam int unsigned CMFS_MAG_W = 16;
	// Width of the coordinate output fields.
	localparam int unsigned CMFS_COORD_W = 17;

	// Cube face codes.
	typedef enum logic [2:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

	// A classified direction: the face, the divisor and the two dividends.
	// sub_u and sub_v say whether the quotient is taken off one half.
	typedef struct packed {
		face_t                 face;
		logic                  degenerate;
		logic                  sub_u;
		logic                  sub_v;
		logic [CMFS_MAG_W-1:0] den;
		logic [CMFS_MAG_W-1:0] num_u;
		logic [CMFS_MAG_W-1:0] num_v;
	} item_t;

endpackage

// ===== hdl/cube_map_face_select_uv_unit.sv =====
// Cube map face selection unit: takes a direction of three signed Q1.15 components and
// returns the cube face (0 +x, 1 -x, 2 +y, 3 -y, 4 +z, 5 -z), the face coordinates u and v
// as unsigned fixed point with FRAC_BITS fraction bits (one is 1 << FRAC_BITS, masked to
// 17 bits), and a flag for the all-zero vector, which yields face 1 and u = v = one half.
// The major axis is the largest magnitude, ties going to x, then y. Quotients truncate
// toward zero. A new direction is taken every cycle and one result leaves every cycle
// while the output is not stalled. The pipeline depth is set by the divider, which
// produces one quotient bit per pipeline stage. A FIFO_DEPTH-entry queue (at least two)
// separates classification from division so that each side stalls on its own.
module cube_map_face_select_uv_unit import cmfs_pkg::*; #(
	parameter int unsigned FRAC_BITS  = CMFS_FRAC_BITS,
	parameter int unsigned FIFO_DEPTH = CMFS_FIFO_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [CMFS_DIR_W-1:0] dir_x,
	input  logic signed [CMFS_DIR_W-1:0] dir_y,
	input  logic signed [CMFS_DIR_W-1:0] dir_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   face,
	output logic [CMFS_COORD_W-1:0]      coord_u,
	output logic [CMFS_COORD_W-1:0]      coord_v,
	output logic                         degenerate
);

	logic  push_valid, push_ready;
	item_t push_item;
	logic  pop_valid, pop_ready;
	item_t pop_item;

	// Classifier.
	cmfs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.dir_x      (dir_x),
		.dir_y      (dir_y),
		.dir_z      (dir_z),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// Queue between the two halves.
	cmfs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Divider and coordinate output.
	cmfs_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (pop_valid),
		.head_ready (pop_ready),
		.head_item  (pop_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.face       (face),
		.coord_u    (coord_u),
		.coord_v    (coord_v),
		.degenerate (degenerate)
	);

endmodule

// ===== hdl/cmfs_front.sv =====
// Front end of the cube map face selection unit: accepts directions and classifies them.
// Depends on cmfs_pkg.
module cmfs_front import cmfs_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [CMFS_DIR_W-1:0] dir_x,
	input  logic signed [CMFS_DIR_W-1:0] dir_y,
	input  logic signed [CMFS_DIR_W-1:0] dir_z,
	output logic                         push_valid,
	input  logic                         push_ready,
	output item_t                        push_item
);

	logic [CMFS_DIR_W-1:0] xb, yb, zb;
	logic [CMFS_MAG_W-1:0] ax, ay, az;
	logic                  xs, ys, zs;
	logic                  x_major, y_major;
	item_t                 item_d;
	item_t                 item_s1;
	logic                  vld_s1;

	assign xb = dir_x;
	assign yb = dir_y;
	assign zb = dir_z;
	assign xs = xb[CMFS_DIR_W-1];
	assign ys = yb[CMFS_DIR_W-1];
	assign zs = zb[CMFS_DIR_W-1];

	// Magnitudes; the most negative value maps to its unsigned magnitude.
	assign ax = xs ? CMFS_MAG_W'(~xb + 1'b1) : xb;
	assign ay = ys ? CMFS_MAG_W'(~yb + 1'b1) : yb;
	assign az = zs ? CMFS_MAG_W'(~zb + 1'b1) : zb;

	// Major axis with ties going to x, then y.
	assign x_major = (ax >= ay) && (ax >= az);
	assign y_major = !x_major && (ay >= az);

	// Face, divisor, dividends and the sign of each quotient term.
	always_comb begin
		item_d.degenerate = 1'b0;
		if (x_major) begin
			item_d.face  = xs ? FACE_NEG_X : FACE_POS_X;
			item_d.den   = ax;
			item_d.num_u = az;
			item_d.num_v = ay;
			item_d.sub_u = zs ^ xs;
			item_d.sub_v = !ys;
		end else if (y_major) begin
			item_d.face  = ys ? FACE_NEG_Y : FACE_POS_Y;
			item_d.den   = ay;
			item_d.num_u = ax;
			item_d.num_v = az;
			item_d.sub_u = !xs;
			item_d.sub_v = zs ^ ys;
		end else begin
			item_d.face  = zs ? FACE_NEG_Z : FACE_POS_Z;
			item_d.den   = az;
			item_d.num_u = ax;
			item_d.num_v = ay;
			item_d.sub_u = !(xs ^ zs);
			item_d.sub_v = !ys;
		end
		// A zero vector divides zero by one, which leaves both coordinates at one half.
		if ((ax == '0) && (ay == '0) && (az == '0)) begin
			item_d.face       = FACE_NEG_X;
			item_d.degenerate = 1'b1;
			item_d.den        = CMFS_MAG_W'(1);
			item_d.num_u      = '0;
			item_d.num_v      = '0;
			item_d.sub_u      = 1'b0;
			item_d.sub_v      = 1'b0;
		end
	end

	// The stage takes a new transaction whenever it is empty or its item moves on.
	assign in_ready   = !vld_s1 || push_ready;
	assign push_valid = vld_s1;
	assign push_item  = item_s1;

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== hdl/cmfs_fifo.sv =====
// Short queue of classified items between the front end and the divider.
// Depends on cmfs_pkg and the assertion macro header.
`include "cube_map_face_select_uv_unit_assert.svh"

module cmfs_fifo import cmfs_pkg::*; #(
	parameter int unsigned DEPTH = CMFS_FIFO_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`CMFS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
	`CMFS_ASSERT_NEXT(a_count_grows, push && !pop, count_q == $past(count_q) + 1'b1)
	`CMFS_ASSERT_NEXT(a_count_drops, pop && !push, count_q == $past(count_q) - 1'b1)

endmodule

// ===== hdl/cmfs_back.sv =====
// Back end of the cube map face selection unit: pipelined dividers and coordinate output.
// Depends on cmfs_pkg and the assertion macro header.
`include "cube_map_face_select_uv_unit_assert.svh"

module cmfs_back import cmfs_pkg::*; #(
	parameter int unsigned FRAC_BITS = CMFS_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	output logic                    head_ready,
	input  item_t                   head_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              face,
	output logic [CMFS_COORD_W-1:0] coord_u,
	output logic [CMFS_COORD_W-1:0] coord_v,
	output logic                    degenerate
);

	// One half in the coordinate format.
	localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

	// Work carried down the divider: partial remainders and quotients of both terms.
	typedef struct packed {
		face_t                 face;
		logic                  degenerate;
		logic                  sub_u;
		logic                  sub_v;
		logic [CMFS_MAG_W-1:0] den;
		logic [CMFS_MAG_W-1:0] rem_u;
		logic [CMFS_MAG_W-1:0] rem_v;
		logic [FRAC_BITS-1:0]  quo_u;
		logic [FRAC_BITS-1:0]  quo_v;
	} div_t;

	div_t                    head_div;
	div_t                    div_in  [FRAC_BITS];
	div_t                    div_nxt [FRAC_BITS];
	div_t                    div_s   [FRAC_BITS];
	logic [FRAC_BITS-1:0]    div_vld_s;
	logic                    adv;
	logic [FRAC_BITS:0]      cu, cv;
	div_t                    last;
	logic                    out_vld_q;
	face_t                   face_q;
	logic [CMFS_COORD_W-1:0] coord_u_q, coord_v_q;
	logic                    deg_q;
	logic                    quo_in_range;
	logic                    deg_out_ok;

	// The whole pipeline moves when the output register is free or being drained.
	assign adv        = !out_vld_q || out_ready;
	assign head_ready = adv;

	// Entry of the divider: the dividend starts as the remainder, the quotient empty.
	always_comb begin
		head_div.face       = head_item.face;
		head_div.degenerate = head_item.degenerate;
		head_div.sub_u      = head_item.sub_u;
		head_div.sub_v      = head_item.sub_v;
		head_div.den        = head_item.den;
		head_div.rem_u      = head_item.num_u;
		head_div.rem_v      = head_item.num_v;
		head_div.quo_u      = '0;
		head_div.quo_v      = '0;
	end

	// One quotient bit per stage. The minor magnitude never exceeds the major one,
	// so the first stage compares without doubling and gives the bit of weight one half.
	for (genvar j = 0; j < FRAC_BITS; j++) begin : g_stage
		logic [CMFS_MAG_W:0] trial_u, trial_v, den_x;
		logic                bit_u, bit_v;

		if (j == 0) begin : g_first
			assign div_in[j] = head_div;
			assign trial_u   = {1'b0, div_in[j].rem_u};
			assign trial_v   = {1'b0, div_in[j].rem_v};
		end else begin : g_next
			assign div_in[j] = div_s[j-1];
			assign trial_u   = {div_in[j].rem_u, 1'b0};
			assign trial_v   = {div_in[j].rem_v, 1'b0};
		end

		assign den_x = {1'b0, div_in[j].den};
		assign bit_u = (trial_u >= den_x);
		assign bit_v = (trial_v >= den_x);

		always_comb begin
			div_nxt[j]       = div_in[j];
			div_nxt[j].rem_u = bit_u ? CMFS_MAG_W'(trial_u - den_x) : CMFS_MAG_W'(trial_u);
			div_nxt[j].rem_v = bit_v ? CMFS_MAG_W'(trial_v - den_x) : CMFS_MAG_W'(trial_v);
			div_nxt[j].quo_u = {div_in[j].quo_u[FRAC_BITS-2:0], bit_u};
			div_nxt[j].quo_v = {div_in[j].quo_v[FRAC_BITS-2:0], bit_v};
		end
	end

	// Stage valids and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			div_vld_s <= {div_vld_s[FRAC_BITS-2:0], head_valid};
			out_vld_q <= div_vld_s[FRAC_BITS-1];
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < FRAC_BITS; i++) begin
				div_s[i] <= div_nxt[i];
			end
		end
	end

	// Coordinates: one half plus or minus the quotient, which never exceeds one half.
	assign last = div_s[FRAC_BITS-1];
	assign cu   = last.sub_u ? HALF - {1'b0, last.quo_u} : HALF + {1'b0, last.quo_u};
	assign cv   = last.sub_v ? HALF - {1'b0, last.quo_v} : HALF + {1'b0, last.quo_v};

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			face_q    <= last.face;
			deg_q     <= last.degenerate;
			coord_u_q <= CMFS_COORD_W'(cu);
			coord_v_q <= CMFS_COORD_W'(cv);
		end
	end

	assign out_valid  = out_vld_q;
	assign face       = face_q;
	assign coord_u    = coord_u_q;
	assign coord_v    = coord_v_q;
	assign degenerate = deg_q;

	// Conditions checked below: quotient range and the fixed zero-vector result.
	assign quo_in_range = ({1'b0, last.quo_u} <= HALF) && ({1'b0, last.quo_v} <= HALF);
	assign deg_out_ok   = (face_q == FACE_NEG_X) &&
		(coord_u_q == CMFS_COORD_W'(HALF)) && (coord_v_q == CMFS_COORD_W'(HALF));

	`CMFS_ASSERT_NOW(a_quo_bound, div_vld_s[FRAC_BITS-1], quo_in_range)
	`CMFS_ASSERT_NOW(a_degenerate_out, out_vld_q && deg_q, deg_out_ok)
	`CMFS_ASSERT_NEXT(a_out_hold, out_vld_q && !out_ready, out_vld_q && $stable(coord_u_q))

endmodule
